// File: rtl/vic_pkg.sv
// package for the vectored interrupt controller: sizes, codes, beat types
// and the table port bundle; depends on nothing
package vic_pkg;

  localparam int NUM_SOURCES   = 32;
  localparam int NUM_ROWS      = (NUM_SOURCES + 1) / 2;
  localparam int NUM_FULL_ROWS = NUM_SOURCES / 2;
  localparam int TBL_DEPTH     = 16;
  localparam int ROW_W         = 4;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RAISE = 2'd2;

  localparam logic [4:0] REG_ENABLE0 = 5'd4;
  localparam logic [4:0] REG_FIQ_LO  = 5'd8;
  localparam logic [4:0] REG_FIQ_HI  = 5'd9;
  localparam logic [4:0] REG_IRQ_LO  = 5'd10;
  localparam logic [4:0] REG_IRQ_HI  = 5'd11;
  localparam logic [4:0] REG_BASE_LO = 5'd12;
  localparam logic [4:0] REG_BASE_HI = 5'd13;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  reg_index;
    logic [15:0] wdata;
    logic        irq_kind;
    logic [4:0]  irq_num;
  } in_t;

  typedef struct packed {
    logic [15:0] rdata;
    logic [29:0] irq_vector;
    logic        fiq_raised;
    logic        irq_raised;
  } out_t;

  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic [9:0]       wr_word;
  } tbl_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PRD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_t;

endpackage

// File: rtl/vic_prio_table.sv
// priority table: one synchronous memory row per slot pair, with row valid bits
// so an unwritten row reads as its reset mapping; depends on vic_pkg
module vic_prio_table (
  input  logic              clk,
  input  logic              rst_n,
  input  vic_pkg::tbl_req_t req,
  output logic [9:0]        rd_word
);
  import vic_pkg::*;

  logic [9:0]       mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] row_vld_r;
  logic [9:0]       data_r;
  logic             vld_r;
  logic [ROW_W-1:0] rrow_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_word;
    end
    if (req.rd_en) begin
      data_r <= mem[req.rd_row];
      vld_r  <= row_vld_r[req.rd_row];
      rrow_r <= req.rd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (req.wr_en) begin
      row_vld_r[req.wr_row] <= 1'b1;
    end
  end

  // reset mapping: slot 2k holds 2k, slot 2k+1 holds 2k+1
  assign rd_word = vld_r ? data_r : {rrow_r, 1'b1, rrow_r, 1'b0};

endmodule

// File: rtl/vectored_interrupt_controller_core.sv
// vectored interrupt controller top level: status, enable and base registers,
// priority scan sequencer and output register; depends on vic_pkg, vic_prio_table
// flow: an item is taken in IDLE and executed in EXEC; a priority-row read passes
// through PRD, an op that recomputes the vector scans rows in SCAN_RD and SCAN_CHK
// until a hit or the last row; one item at a time: in_ready returns when DONE
// registers the output beat, which DONE holds off while a previous beat is stalled
// reset: synchronous active-low rst_n, status all ones, enables and base zero,
// priority slot i maps to source i, no output beat pending
module vectored_interrupt_controller_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vic_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output vic_pkg::out_t out_data
);
  import vic_pkg::*;

  state_t           state_r, state_nxt;
  in_t              item_r, item_nxt;
  logic [15:0]      pend_r [4];
  logic [15:0]      pend_nxt [4];
  logic [15:0]      en_r [4];
  logic [15:0]      en_nxt [4];
  logic [28:0]      base_r, base_nxt;
  logic [1:0]       code_r, code_nxt;
  logic [29:0]      entry_r, entry_nxt;
  logic [ROW_W-1:0] scan_row_r, scan_row_nxt;
  logic [15:0]      rdata_r, rdata_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  tbl_req_t         tbl_req;
  logic [9:0]       tbl_word;

  logic [31:0]      live;
  logic [3:0]       pair;
  logic             pair_ok;
  logic             prio_rd;
  logic             recompute;
  logic             hit_lo;
  logic             hit_hi;
  logic             hi_ok;
  logic             last_row;
  logic [15:0]      bus_rdata;

  function automatic logic [29:0] vec_of(input logic [28:0] base, input logic [1:0] code,
                                         input logic [4:0] slot);
    logic [5:0]  s1;
    logic [10:0] off;
    s1  = {1'b0, slot} + 6'd1;
    off = 11'(s1) << ({1'b0, code} + 3'd2);
    return {1'b0, base} + {19'd0, off};
  endfunction

  function automatic logic hi_ok_pair(input logic [3:0] k);
    return {1'b0, k} < 5'(NUM_FULL_ROWS);
  endfunction

  vic_prio_table u_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tbl_req),
    .rd_word (tbl_word)
  );

  assign live     = {~pend_r[3] & en_r[3], ~pend_r[2] & en_r[2]};
  assign pair     = item_r.reg_index[3:0];
  assign pair_ok  = item_r.reg_index[4] && ({1'b0, pair} < 5'(NUM_ROWS));
  assign prio_rd  = (item_r.op == OP_READ) && pair_ok;
  assign recompute = (item_r.op == OP_RAISE) ||
                     ((item_r.op == OP_WRITE) &&
                      ((item_r.reg_index < REG_FIQ_LO) || (item_r.reg_index == REG_BASE_LO) ||
                       (item_r.reg_index == REG_BASE_HI) || pair_ok));
  assign hit_lo   = live[tbl_word[4:0]];
  assign hi_ok    = {1'b0, scan_row_r} < 5'(NUM_FULL_ROWS);
  assign hit_hi   = hi_ok && live[tbl_word[9:5]];
  assign last_row = scan_row_r == ROW_W'(NUM_ROWS - 1);

  always_comb begin
    bus_rdata = '0;
    if (item_r.reg_index < REG_ENABLE0) begin
      bus_rdata = pend_r[item_r.reg_index[1:0]];
    end else if (item_r.reg_index < REG_FIQ_LO) begin
      bus_rdata = en_r[item_r.reg_index[1:0]];
    end else begin
      case (item_r.reg_index)
        REG_FIQ_LO:  bus_rdata = base_r[15:0];
        REG_FIQ_HI:  bus_rdata = {3'd0, base_r[28:16]};
        REG_IRQ_LO:  bus_rdata = entry_r[15:0];
        REG_IRQ_HI:  bus_rdata = {2'd0, entry_r[29:16]};
        REG_BASE_LO: bus_rdata = {base_r[15:3], 1'b0, code_r};
        REG_BASE_HI: bus_rdata = {3'd0, base_r[28:16]};
        default:     bus_rdata = '0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (prio_rd) state_nxt = ST_PRD;
        else if (recompute) state_nxt = ST_SCAN_RD;
        else state_nxt = ST_DONE;
      end
      ST_PRD:     state_nxt = ST_DONE;
      ST_SCAN_RD: state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (hit_lo || hit_hi || last_row) state_nxt = ST_DONE;
        else state_nxt = ST_SCAN_RD;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    pend_nxt      = pend_r;
    en_nxt        = en_r;
    base_nxt      = base_r;
    code_nxt      = code_r;
    entry_nxt     = entry_r;
    scan_row_nxt  = scan_row_r;
    rdata_nxt     = rdata_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    tbl_req       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) item_nxt = in_data;
      end
      ST_EXEC: begin
        rdata_nxt    = '0;
        scan_row_nxt = '0;
        case (item_r.op)
          OP_READ: begin
            rdata_nxt      = bus_rdata;
            tbl_req.rd_en  = prio_rd;
            tbl_req.rd_row = pair;
          end
          OP_WRITE: begin
            if (item_r.reg_index < REG_ENABLE0) begin
              pend_nxt[item_r.reg_index[1:0]] = pend_r[item_r.reg_index[1:0]] | item_r.wdata;
            end else if (item_r.reg_index < REG_FIQ_LO) begin
              en_nxt[item_r.reg_index[1:0]] = item_r.wdata;
            end else if (item_r.reg_index == REG_BASE_LO) begin
              base_nxt = {base_r[28:16], item_r.wdata[15:3], 3'd0};
              code_nxt = item_r.wdata[1:0];
            end else if (item_r.reg_index == REG_BASE_HI) begin
              base_nxt = {item_r.wdata[12:0], base_r[15:0]};
            end
            tbl_req.wr_en   = pair_ok;
            tbl_req.wr_row  = pair;
            tbl_req.wr_word = {item_r.wdata[12:8], item_r.wdata[4:0]};
          end
          OP_RAISE: begin
            pend_nxt[{item_r.irq_kind, item_r.irq_num[4]}][item_r.irq_num[3:0]] = 1'b0;
          end
          default: ;
        endcase
      end
      ST_PRD: begin
        rdata_nxt = {3'd0, hi_ok_pair(pair) ? tbl_word[9:5] : 5'd0, 3'd0, tbl_word[4:0]};
      end
      ST_SCAN_RD: begin
        tbl_req.rd_en  = 1'b1;
        tbl_req.rd_row = scan_row_r;
      end
      ST_SCAN_CHK: begin
        if (hit_lo) begin
          entry_nxt = vec_of(base_r, code_r, {scan_row_r, 1'b0});
        end else if (hit_hi) begin
          entry_nxt = vec_of(base_r, code_r, {scan_row_r, 1'b1});
        end else if (last_row) begin
          entry_nxt = {1'b0, base_r};
        end else begin
          scan_row_nxt = scan_row_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_nxt.rdata      = rdata_r;
          out_nxt.irq_vector = entry_r;
          out_nxt.fiq_raised = (item_r.op == OP_RAISE) && !item_r.irq_kind;
          out_nxt.irq_raised = (item_r.op == OP_RAISE) && item_r.irq_kind;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        pend_r[i] <= 16'hFFFF;
        en_r[i]   <= '0;
      end
      base_r      <= '0;
      code_r      <= '0;
      entry_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      en_r        <= en_nxt;
      base_r      <= base_nxt;
      code_r      <= code_nxt;
      entry_r     <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    scan_row_r <= scan_row_nxt;
    rdata_r    <= rdata_nxt;
    out_r      <= out_nxt;
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/vic_checker.sv
// port-level checks for the vectored interrupt controller top level,
// bound to it below; depends on vic_pkg
module vic_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input vic_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input vic_pkg::out_t out_data
);
  import vic_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.fiq_raised && out_data.irq_raised))
    else $error("fiq and irq raised on one beat");

  a_raise_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.fiq_raised || out_data.irq_raised) |-> out_data.rdata == 16'd0)
    else $error("raise beat carries read data");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat right after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken before first finished");

endmodule

bind vectored_interrupt_controller_core vic_checker u_vic_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// testbench for vectored_interrupt_controller_core: directed table then random
// bus reads, writes and raises, scored against an in-file predictor; needs vic_pkg
module tb_top;
  import vic_pkg::*;

  localparam logic [1:0] OP_NONE       = 2'd3;
  localparam logic [4:0] REG_STATUS0   = 5'd0;
  localparam logic [4:0] REG_STATUS2   = 5'd2;
  localparam logic [4:0] REG_STATUS3   = 5'd3;
  localparam logic [4:0] REG_ENABLE3   = 5'd7;
  localparam logic [4:0] REG_SPARE_LO  = 5'd14;
  localparam logic [4:0] REG_SPARE_HI  = 5'd15;
  localparam logic [4:0] REG_PRIO0     = 5'd16;
  localparam logic [4:0] REG_PRIO_LAST = 5'd31;
  localparam logic       KIND_FIQ      = 1'b0;
  localparam logic       KIND_IRQ      = 1'b1;
  localparam int         RAND_ITEMS    = 1150;
  localparam int         SETTLE_CYCLES = 40;

  typedef struct {
    in_t  beat;
    bit   typed;
    out_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // predictor state
  logic [15:0] pend_q [4];
  logic [15:0] enab_q [4];
  logic [4:0]  prio_q [32];
  logic [28:0] base_q;
  logic [1:0]  bsize_q;
  logic [29:0] vec_q;

  out_t     bus_resp_q [$];
  dir_row_t dir_rows [$];
  bit       calm;
  int       err_count;
  int       n_read, n_write, n_raise, n_other, n_resp;

  vectored_interrupt_controller_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void refresh_vector();
    logic [31:0] live;
    logic [31:0] addr;
    bit          hit;
    live = {~pend_q[3] & enab_q[3], ~pend_q[2] & enab_q[2]};
    addr = {3'b000, base_q};
    hit  = 1'b0;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      if (!hit && live[prio_q[s]]) begin
        addr = addr + (32'(s + 1) << (2 + int'(bsize_q)));
        hit  = 1'b1;
      end
    end
    vec_q = addr[29:0];
  endfunction

  function automatic out_t step_controller(in_t b);
    out_t        r;
    logic [4:0]  idx;
    logic [1:0]  w;
    int          a;
    bit          dirty;
    r   = '0;
    idx = b.reg_index;
    a   = 2 * int'(idx - REG_PRIO0);
    case (b.op)
      OP_READ: begin
        if (idx < REG_ENABLE0) r.rdata = pend_q[idx[1:0]];
        else if (idx < REG_FIQ_LO) r.rdata = enab_q[idx[1:0]];
        else if (idx >= REG_PRIO0) begin
          if (a < NUM_SOURCES) begin
            r.rdata[4:0] = prio_q[a];
            if (a + 1 < NUM_SOURCES) r.rdata[12:8] = prio_q[a + 1];
          end
        end else begin
          case (idx)
            REG_FIQ_LO:  r.rdata = base_q[15:0];
            REG_FIQ_HI:  r.rdata = {3'b000, base_q[28:16]};
            REG_IRQ_LO:  r.rdata = vec_q[15:0];
            REG_IRQ_HI:  r.rdata = {2'b00, vec_q[29:16]};
            REG_BASE_LO: r.rdata = {base_q[15:3], 1'b0, bsize_q};
            REG_BASE_HI: r.rdata = {3'b000, base_q[28:16]};
            default: ;
          endcase
        end
      end
      OP_WRITE: begin
        dirty = 1'b1;
        if (idx < REG_ENABLE0) pend_q[idx[1:0]] = pend_q[idx[1:0]] | b.wdata;
        else if (idx < REG_FIQ_LO) enab_q[idx[1:0]] = b.wdata;
        else if (idx == REG_BASE_LO) begin
          base_q[15:3] = b.wdata[15:3];
          bsize_q      = b.wdata[1:0];
        end else if (idx == REG_BASE_HI) base_q[28:16] = b.wdata[12:0];
        else if (idx >= REG_PRIO0 && a < NUM_SOURCES) begin
          prio_q[a] = b.wdata[4:0];
          if (a + 1 < NUM_SOURCES) prio_q[a + 1] = b.wdata[12:8];
        end else dirty = 1'b0;
        if (dirty) refresh_vector();
      end
      OP_RAISE: begin
        w = {b.irq_kind, b.irq_num[4]};
        pend_q[w][b.irq_num[3:0]] = 1'b0;
        refresh_vector();
        if (b.irq_kind == KIND_IRQ) r.irq_raised = 1'b1;
        else r.fiq_raised = 1'b1;
      end
      default: ;
    endcase
    r.irq_vector = vec_q;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  function automatic dir_row_t bus_row(logic [1:0] op, logic [4:0] idx, logic [15:0] wd,
                                       bit typed = 1'b0, logic [15:0] rd = '0);
    dir_row_t row;
    row.beat           = '0;
    row.beat.op        = op;
    row.beat.reg_index = idx;
    row.beat.wdata     = wd;
    row.typed          = typed;
    row.want           = '0;
    row.want.rdata     = rd;
    return row;
  endfunction

  function automatic dir_row_t raise_row(logic kind, logic [4:0] num);
    dir_row_t row;
    row                = bus_row(OP_RAISE, REG_STATUS0, 16'h0000);
    row.beat.irq_kind  = kind;
    row.beat.irq_num   = num;
    return row;
  endfunction

  function automatic in_t rand_item();
    in_t it;
    int  pick;
    it   = in_t'(29'($urandom));
    pick = int'($urandom_range(0, 99));
    if (pick < 30) it.op = OP_RAISE;
    else if (pick < 65) it.op = OP_WRITE;
    else if (pick < 95) it.op = OP_READ;
    else it.op = OP_NONE;
    if (it.op == OP_RAISE) it.irq_kind = ($urandom_range(0, 9) < 7) ? KIND_IRQ : KIND_FIQ;
    if (it.op == OP_WRITE) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 25) begin
        it.reg_index = 5'($urandom_range(REG_STATUS0, REG_STATUS3));
        if ($urandom_range(0, 3) != 0) it.wdata = 16'd1 << $urandom_range(0, 15);
      end else if (pick < 45) begin
        it.reg_index = 5'($urandom_range(REG_ENABLE0, REG_ENABLE3));
        pick = int'($urandom_range(0, 5));
        if (pick == 0) it.wdata = '0;
        else if (pick == 1) it.wdata = '1;
      end else if (pick < 55) begin
        it.reg_index = 5'($urandom_range(REG_BASE_LO, REG_BASE_HI));
      end else if (pick < 90) begin
        it.reg_index = 5'($urandom_range(REG_PRIO0, REG_PRIO_LAST));
      end
    end
    return it;
  endfunction

  task automatic send_beat(input in_t beat, input bit typed, input out_t want);
    out_t pred;
    int   gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    pred = step_controller(beat);
    bus_resp_q.push_back(typed ? want : pred);
    case (beat.op)
      OP_READ:  n_read++;
      OP_WRITE: n_write++;
      OP_RAISE: n_raise++;
      default:  n_other++;
    endcase
  endtask

  task automatic drain_responses();
    in_valid <= 1'b0;
    do @(posedge clk); while (bus_resp_q.size() != 0);
  endtask

  // response scoreboard
  always @(posedge clk) begin : resp_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bus_resp_q.size() == 0) begin
        $error("response beat with nothing expected: %h", out_data);
        err_count++;
      end else begin
        want = bus_resp_q.pop_front();
        n_resp++;
        if (out_data.rdata !== want.rdata) begin
          $error("rdata: expected %h, got %h", want.rdata, out_data.rdata);
          err_count++;
        end
        if (out_data.irq_vector !== want.irq_vector) begin
          $error("irq_vector: expected %h, got %h", want.irq_vector, out_data.irq_vector);
          err_count++;
        end
        if (out_data.fiq_raised !== want.fiq_raised) begin
          $error("fiq_raised: expected %b, got %b", want.fiq_raised, out_data.fiq_raised);
          err_count++;
        end
        if (out_data.irq_raised !== want.irq_raised) begin
          $error("irq_raised: expected %b, got %b", want.irq_raised, out_data.irq_raised);
          err_count++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int on_len, off_len;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      on_len  = int'($urandom_range(1, 12));
      off_len = idle_len();
      out_ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      if (off_len > 0) begin
        out_ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    calm      = 1'b0;
    err_count = 0;
    for (int i = 0; i < 4; i++) begin
      pend_q[i] = 16'hFFFF;
      enab_q[i] = 16'h0000;
    end
    for (int i = 0; i < 32; i++) prio_q[i] = 5'(i);
    base_q  = '0;
    bsize_q = '0;
    vec_q   = '0;

    // reset-state reads and ignored accesses, then extremes of base, table and sources
    dir_rows.push_back(bus_row(OP_READ, REG_STATUS0, 16'h0000, 1'b1, 16'hFFFF));
    dir_rows.push_back(bus_row(OP_READ, REG_STATUS3, 16'hFFFF, 1'b1, 16'hFFFF));
    dir_rows.push_back(bus_row(OP_READ, REG_ENABLE3, 16'h0000, 1'b1, 16'h0000));
    dir_rows.push_back(bus_row(OP_READ, REG_SPARE_LO, 16'h0000, 1'b1, 16'h0000));
    dir_rows.push_back(bus_row(OP_READ, REG_PRIO0, 16'h0000, 1'b1, 16'h0100));
    dir_rows.push_back(bus_row(OP_READ, REG_PRIO_LAST, 16'h0000, 1'b1, 16'h1F1E));
    dir_rows.push_back(bus_row(OP_NONE, REG_STATUS0, 16'hFFFF, 1'b1, 16'h0000));
    dir_rows.push_back(bus_row(OP_WRITE, REG_SPARE_HI, 16'hFFFF, 1'b1, 16'h0000));
    dir_rows.push_back(bus_row(OP_WRITE, REG_IRQ_LO, 16'hFFFF, 1'b1, 16'h0000));
    dir_rows.push_back(bus_row(OP_WRITE, REG_ENABLE0 + 5'd2, 16'hFFFF));
    dir_rows.push_back(bus_row(OP_WRITE, REG_ENABLE3, 16'hFFFF));
    dir_rows.push_back(bus_row(OP_WRITE, REG_BASE_LO, 16'hFFFF));
    dir_rows.push_back(bus_row(OP_WRITE, REG_BASE_HI, 16'hFFFF));
    dir_rows.push_back(raise_row(KIND_IRQ, 5'd31));
    dir_rows.push_back(raise_row(KIND_FIQ, 5'd0));
    dir_rows.push_back(raise_row(KIND_FIQ, 5'd31));
    dir_rows.push_back(bus_row(OP_READ, REG_IRQ_LO, 16'h0000));
    dir_rows.push_back(bus_row(OP_READ, REG_IRQ_HI, 16'h0000));
    dir_rows.push_back(bus_row(OP_READ, REG_FIQ_LO, 16'h0000));
    dir_rows.push_back(bus_row(OP_READ, REG_FIQ_HI, 16'h0000));
    dir_rows.push_back(bus_row(OP_WRITE, REG_PRIO_LAST, 16'hFFFF));
    dir_rows.push_back(bus_row(OP_WRITE, REG_STATUS3, 16'h8000));
    dir_rows.push_back(raise_row(KIND_IRQ, 5'd0));
    dir_rows.push_back(bus_row(OP_READ, REG_STATUS2, 16'h0000));
    dir_rows.push_back(bus_row(OP_WRITE, REG_PRIO0, 16'h0000));
    dir_rows.push_back(bus_row(OP_READ, REG_BASE_LO, 16'h0000));
    dir_rows.push_back(bus_row(OP_WRITE, REG_BASE_LO, 16'h0000));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    drain_responses();

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == RAND_ITEMS / 3) drain_responses();
      calm = (k >= RAND_ITEMS / 2 && k < RAND_ITEMS / 2 + 150);
      send_beat(rand_item(), 1'b0, '0);
    end

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d reads, %0d writes, %0d raises, %0d no-op beats sent",
             n_read, n_write, n_raise, n_other);
    $display("run: %0d response beats scored, %0d errors", n_resp, err_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/vic_pkg.sv
rtl/vic_prio_table.sv
rtl/vectored_interrupt_controller_core.sv
rtl/vic_checker.sv
dv/tb_top.sv
